FILE: sv/msd_pkg.sv
`timescale 1ns / 1ps
package msd_pkg;

  localparam int CODE_MAX_DEF = 7;

  localparam int SAMPLE_W = 12;
  localparam int TIME_W   = 32;
  localparam int MS_W     = 16;
  localparam int SYM_W    = 7;
  localparam int CFG_IDX_W = 3;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_MARK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DASH_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LETTER_GAP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_GAP   = 3'd5;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST  = 12'd1000;
  localparam logic [MS_W-1:0]     DEBOUNCE_RST   = 16'd50;
  localparam logic [MS_W-1:0]     MIN_MARK_RST   = 16'd100;
  localparam logic [MS_W-1:0]     DASH_MIN_RST   = 16'd400;
  localparam logic [MS_W-1:0]     LETTER_GAP_RST = 16'd1100;
  localparam logic [MS_W-1:0]     WORD_GAP_RST   = 16'd1800;

  localparam logic [SYM_W-1:0] CH_DOT   = 7'h2E;
  localparam logic [SYM_W-1:0] CH_DASH  = 7'h2D;
  localparam logic [SYM_W-1:0] CH_SPACE = 7'h20;
  localparam logic [SYM_W-1:0] CH_UNKNOWN = 7'h3F;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MARK,
    PH_DEBOUNCE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DOT,
    KIND_DASH,
    KIND_LETTER,
    KIND_SPACE
  } kind_t;

  typedef struct packed {
    logic [2:0]       len;
    logic [4:0]       bits;  // bit i set: element i is a dash
    logic [SYM_W-1:0] ch;
  } sym_entry_t;

  localparam int ROM_DEPTH = 36;

  localparam sym_entry_t SYM_ROM [ROM_DEPTH] = '{
    '{3'd2, 5'd2,  7'h41}, '{3'd4, 5'd1,  7'h42}, '{3'd4, 5'd5,  7'h43},
    '{3'd3, 5'd1,  7'h44}, '{3'd1, 5'd0,  7'h45}, '{3'd4, 5'd4,  7'h46},
    '{3'd3, 5'd3,  7'h47}, '{3'd4, 5'd0,  7'h48}, '{3'd2, 5'd0,  7'h49},
    '{3'd4, 5'd14, 7'h4A}, '{3'd3, 5'd5,  7'h4B}, '{3'd4, 5'd2,  7'h4C},
    '{3'd2, 5'd3,  7'h4D}, '{3'd2, 5'd1,  7'h4E}, '{3'd3, 5'd7,  7'h4F},
    '{3'd4, 5'd6,  7'h50}, '{3'd4, 5'd11, 7'h51}, '{3'd3, 5'd2,  7'h52},
    '{3'd3, 5'd0,  7'h53}, '{3'd1, 5'd1,  7'h54}, '{3'd3, 5'd4,  7'h55},
    '{3'd4, 5'd8,  7'h56}, '{3'd3, 5'd6,  7'h57}, '{3'd4, 5'd9,  7'h58},
    '{3'd4, 5'd13, 7'h59}, '{3'd4, 5'd3,  7'h5A}, '{3'd5, 5'd31, 7'h30},
    '{3'd5, 5'd30, 7'h31}, '{3'd5, 5'd28, 7'h32}, '{3'd5, 5'd24, 7'h33},
    '{3'd5, 5'd16, 7'h34}, '{3'd5, 5'd0,  7'h35}, '{3'd5, 5'd1,  7'h36},
    '{3'd5, 5'd3,  7'h37}, '{3'd5, 5'd7,  7'h38}, '{3'd5, 5'd15, 7'h39}
  };

endpackage

FILE: sv/msd_letter_lookup.sv
`timescale 1ns / 1ps
module msd_letter_lookup
  import msd_pkg::*;
#(
  parameter int CODE_MAX = CODE_MAX_DEF,
  parameter int CNT_W    = $clog2(CODE_MAX + 1)
) (
  input  logic [CODE_MAX-1:0] code_bits,
  input  logic [CNT_W-1:0]    code_cnt,
  input  logic                code_ovf,
  output logic [SYM_W-1:0]    letter
);

  // 36 independent compares against the constant table, first hit wins
  always_comb begin
    logic found;
    found  = 1'b0;
    letter = CH_UNKNOWN;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      if (!found && !code_ovf &&
          code_cnt == CNT_W'(SYM_ROM[i].len) &&
          code_bits == CODE_MAX'(SYM_ROM[i].bits)) begin
        found  = 1'b1;
        letter = SYM_ROM[i].ch;
      end
    end
  end

endmodule

FILE: sv/morse_sample_decoder.sv
`timescale 1ns / 1ps
// Morse decoder over timestamped sensor samples.
//
// Input stream: one request per sample, in_tdata = {now_ms, sample} packed
// from bit 0. Result stream: up to three results per sample, in the order
// letter, word space, dot/dash; out_tdata carries the ASCII symbol,
// out_tuser the kind, out_tlast marks the final result of a sample. A
// sample that closes nothing produces no result at all.
// Config: cfg_valid/cfg_index/cfg_data, always ready; write only while the
// block is idle. Indexes 6 and 7 are ignored.
//
// A sample lands in the input register at its accept edge and is decoded
// there once the result buffer is free; its results are registered into
// that buffer, which drives out_*. Throughput: one sample per cycle if
// it yields one result at most and the receiver takes it; otherwise the
// next sample waits for the single result port to empty the 3-entry buffer.
// When the receiver stalls, the buffer holds, the next sample waits in
// the input register and in_tready drops once that register is full.
// Reset (rst_n low, synchronous) restores the default timings, clears the
// decoder state and empties both registers.
module morse_sample_decoder
  import msd_pkg::*;
#(
  parameter int CODE_MAX = CODE_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [47:0]          in_tdata,   // [11:0] sample, [43:12] now_ms
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [6:0] symbol
  output logic [1:0]           out_tuser,  // [1:0] kind
  output logic                 out_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MS_W-1:0]      cfg_data
);

  localparam int CNT_W = $clog2(CODE_MAX + 1);

  // configuration
  logic [SAMPLE_W-1:0] thr_r;
  logic [MS_W-1:0]     deb_r, min_r, dash_r, lgap_r, wgap_r;

  // input register
  logic                in_v_r;
  logic [SAMPLE_W-1:0] in_sample_r;
  logic [TIME_W-1:0]   in_now_r;

  // decoder state
  phase_t            phase_r, phase_nxt;
  logic [TIME_W-1:0] mark_start_r, mark_start_nxt;
  logic [TIME_W-1:0] mark_end_r, mark_end_nxt;
  logic [TIME_W-1:0] last_done_r, last_done_nxt;
  logic [CODE_MAX-1:0] elem_bits_r, elem_bits_nxt;
  logic [CNT_W-1:0]    elem_cnt_r, elem_cnt_nxt;
  logic                ovf_r, ovf_nxt;

  // result buffer
  logic [SYM_W-1:0] res_sym_r [3];
  kind_t            res_kind_r [3];
  logic [1:0]       res_cnt_r, res_idx_r;
  logic [SYM_W-1:0] res_sym_nxt [3];
  kind_t            res_kind_nxt [3];
  logic [1:0]       res_n;

  logic              accept, fire, pop, buf_last, buf_free;
  logic              is_mark, letter_close, add_space, elem_emit, elem_dash;
  logic [TIME_W-1:0] gap, dur, since_rise;
  logic [SYM_W-1:0]  letter;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESHOLD_RST;
      deb_r  <= DEBOUNCE_RST;
      min_r  <= MIN_MARK_RST;
      dash_r <= DASH_MIN_RST;
      lgap_r <= LETTER_GAP_RST;
      wgap_r <= WORD_GAP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_THRESHOLD:  thr_r  <= cfg_data[SAMPLE_W-1:0];
        CFG_DEBOUNCE:   deb_r  <= cfg_data;
        CFG_MIN_MARK:   min_r  <= cfg_data;
        CFG_DASH_MIN:   dash_r <= cfg_data;
        CFG_LETTER_GAP: lgap_r <= cfg_data;
        CFG_WORD_GAP:   wgap_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshakes
  assign pop      = out_tvalid && out_tready;
  assign buf_last = (res_idx_r == res_cnt_r - 2'd1);
  assign buf_free = (res_cnt_r == 2'd0) || (pop && buf_last);
  assign fire     = in_v_r && buf_free;
  assign in_tready = !in_v_r || fire;
  assign accept   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (accept) begin
      in_v_r <= 1'b1;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_sample_r <= in_tdata[11:0];
      in_now_r    <= in_tdata[43:12];
    end
  end

  msd_letter_lookup #(
    .CODE_MAX (CODE_MAX),
    .CNT_W    (CNT_W)
  ) u_lookup (
    .code_bits (elem_bits_r),
    .code_cnt  (elem_cnt_r),
    .code_ovf  (ovf_r),
    .letter    (letter)
  );

  assign is_mark    = in_sample_r < thr_r;
  assign gap        = in_now_r - last_done_r;
  assign dur        = mark_end_r - mark_start_r;
  assign since_rise = in_now_r - mark_end_r;

  assign letter_close = ((elem_cnt_r != '0) || ovf_r) && (gap > TIME_W'(lgap_r));
  assign add_space    = letter_close && (gap > TIME_W'(wgap_r));
  assign elem_dash    = dur >= TIME_W'(dash_r);

  // phase machine plus the element store
  always_comb begin
    logic [CODE_MAX-1:0] bits_c;
    logic [CNT_W-1:0]    cnt_c;
    logic                ovf_c;
    bits_c = letter_close ? '0 : elem_bits_r;
    cnt_c  = letter_close ? '0 : elem_cnt_r;
    ovf_c  = letter_close ? 1'b0 : ovf_r;

    phase_nxt      = phase_r;
    mark_start_nxt = mark_start_r;
    mark_end_nxt   = mark_end_r;
    last_done_nxt  = last_done_r;
    elem_emit      = 1'b0;

    unique case (phase_r)
      PH_MARK: begin
        if (!is_mark) begin
          mark_end_nxt = in_now_r;
          phase_nxt    = PH_DEBOUNCE;
        end
      end
      PH_DEBOUNCE: begin
        if (is_mark) begin
          phase_nxt = PH_MARK;
        end else if (since_rise >= TIME_W'(deb_r)) begin
          elem_emit     = dur > TIME_W'(min_r);
          last_done_nxt = in_now_r;
          phase_nxt     = PH_IDLE;
        end
      end
      default: begin
        if (is_mark) begin
          mark_start_nxt = in_now_r;
          phase_nxt      = PH_MARK;
        end
      end
    endcase

    elem_bits_nxt = bits_c;
    elem_cnt_nxt  = cnt_c;
    ovf_nxt       = ovf_c;
    if (elem_emit) begin
      if (cnt_c < CNT_W'(CODE_MAX)) begin
        elem_bits_nxt = bits_c | (CODE_MAX'(elem_dash) << cnt_c);
        elem_cnt_nxt  = cnt_c + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  // pack the results of this sample into consecutive slots
  always_comb begin
    logic [1:0] k;
    k = 2'd0;
    for (int i = 0; i < 3; i++) begin
      res_sym_nxt[i]  = CH_DOT;
      res_kind_nxt[i] = KIND_DOT;
    end
    if (letter_close) begin
      res_sym_nxt[0]  = letter;
      res_kind_nxt[0] = KIND_LETTER;
      k = 2'd1;
      if (add_space) begin
        res_sym_nxt[1]  = CH_SPACE;
        res_kind_nxt[1] = KIND_SPACE;
        k = 2'd2;
      end
    end
    if (elem_emit) begin
      res_sym_nxt[k]  = elem_dash ? CH_DASH : CH_DOT;
      res_kind_nxt[k] = elem_dash ? KIND_DASH : KIND_DOT;
      k = k + 2'd1;
    end
    res_n = k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      mark_start_r <= '0;
      mark_end_r   <= '0;
      last_done_r  <= '0;
      elem_bits_r  <= '0;
      elem_cnt_r   <= '0;
      ovf_r        <= 1'b0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      mark_start_r <= mark_start_nxt;
      mark_end_r   <= mark_end_nxt;
      last_done_r  <= last_done_nxt;
      elem_bits_r  <= elem_bits_nxt;
      elem_cnt_r   <= elem_cnt_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r <= 2'd0;
      res_idx_r <= 2'd0;
    end else if (fire) begin
      res_cnt_r <= res_n;
      res_idx_r <= 2'd0;
    end else if (pop) begin
      if (buf_last) begin
        res_cnt_r <= 2'd0;
        res_idx_r <= 2'd0;
      end else begin
        res_idx_r <= res_idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < 3; i++) begin
        res_sym_r[i]  <= res_sym_nxt[i];
        res_kind_r[i] <= res_kind_nxt[i];
      end
    end
  end

  assign out_tvalid = (res_cnt_r != 2'd0);
  assign out_tdata  = {1'b0, res_sym_r[res_idx_r]};
  assign out_tuser  = res_kind_r[res_idx_r];
  assign out_tlast  = buf_last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    elem_cnt_r <= CNT_W'(CODE_MAX))
    else $error("element count beyond store size");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> elem_cnt_r == CNT_W'(CODE_MAX))
    else $error("overflow flag set with store not full");

  a_dot_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DOT |-> out_tdata[SYM_W-1:0] == CH_DOT)
    else $error("dot result with wrong symbol");

  a_fire_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_n != 2'd0 |=> out_tvalid && res_idx_r == 2'd0)
    else $error("decoded results not presented");

endmodule

FILE: sim/tb_morse_sample_decoder.sv
`timescale 1ns / 1ps
module tb_morse_sample_decoder;
  import msd_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam logic [SYM_W-1:0] CH_A = 7'h41;  // 'A'
  // indexes past the last register
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    kind_t            kind;
    logic             last;
  } sym_res_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] level;
    logic [TIME_W-1:0]   stamp;
    logic                typed;
    logic [SYM_W-1:0]    symbol;
    kind_t               kind;
  } dir_row_t;

  // default timings; typed rows give the single result of that sample
  localparam dir_row_t DIR_ROWS [26] = '{
    '{12'd4095, 32'd0,          1'b0, 7'd0,    KIND_DOT},
    '{12'd0,    32'd10,         1'b0, 7'd0,    KIND_DOT},
    '{12'd0,    32'd200,        1'b0, 7'd0,    KIND_DOT},
    '{12'd4095, 32'd250,        1'b0, 7'd0,    KIND_DOT},
    '{12'd2000, 32'd300,        1'b1, CH_DOT,  KIND_DOT},
    '{12'd999,  32'd400,        1'b0, 7'd0,    KIND_DOT},
    '{12'd1000, 32'd900,        1'b0, 7'd0,    KIND_DOT},
    '{12'd500,  32'd920,        1'b0, 7'd0,    KIND_DOT},   // dip resumes the mark
    '{12'd3000, 32'd950,        1'b0, 7'd0,    KIND_DOT},
    '{12'd3000, 32'd1000,       1'b1, CH_DASH, KIND_DASH},
    '{12'd0,    32'd1010,       1'b0, 7'd0,    KIND_DOT},
    '{12'd4095, 32'd1110,       1'b0, 7'd0,    KIND_DOT},
    '{12'd4095, 32'd1160,       1'b0, 7'd0,    KIND_DOT},   // noise mark at min length
    '{12'd4095, 32'd2261,       1'b1, CH_A,    KIND_LETTER},
    '{12'd0,    32'd2300,       1'b0, 7'd0,    KIND_DOT},
    '{12'd4095, 32'd2500,       1'b0, 7'd0,    KIND_DOT},
    '{12'd4095, 32'd2550,       1'b0, 7'd0,    KIND_DOT},
    '{12'd0,    32'd4351,       1'b0, 7'd0,    KIND_DOT},   // letter + space
    '{12'd4095, 32'd4751,       1'b0, 7'd0,    KIND_DOT},
    '{12'd4095, 32'd4801,       1'b0, 7'd0,    KIND_DOT},   // dash at exact dash length
    '{12'd0,    32'd4900,       1'b0, 7'd0,    KIND_DOT},
    '{12'd4095, 32'd5850,       1'b0, 7'd0,    KIND_DOT},
    '{12'd4095, 32'd6700,       1'b0, 7'd0,    KIND_DOT},   // letter + space + dash
    '{12'd0,    32'hFFFF_FFFF,  1'b0, 7'd0,    KIND_DOT},
    '{12'd4095, 32'h0000_0064,  1'b0, 7'd0,    KIND_DOT},   // mark spans the wrap
    '{12'd4095, 32'h0000_0096,  1'b0, 7'd0,    KIND_DOT}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [47:0]          in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;
  logic [1:0]           out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MS_W-1:0]      cfg_data = '0;

  morse_sample_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // decoder model state
  logic [SAMPLE_W-1:0] thr_r        = THRESHOLD_RST;
  logic [MS_W-1:0]     debounce_r   = DEBOUNCE_RST;
  logic [MS_W-1:0]     min_mark_r   = MIN_MARK_RST;
  logic [MS_W-1:0]     dash_min_r   = DASH_MIN_RST;
  logic [MS_W-1:0]     letter_gap_r = LETTER_GAP_RST;
  logic [MS_W-1:0]     word_gap_r   = WORD_GAP_RST;
  phase_t              ph           = PH_IDLE;
  logic [TIME_W-1:0]   mark_start   = '0;
  logic [TIME_W-1:0]   mark_end     = '0;
  logic [TIME_W-1:0]   last_done    = '0;
  logic [6:0]          elem_bits    = '0;
  logic [2:0]          elem_cnt     = '0;
  logic                ovf          = 1'b0;

  sym_res_t          step_res[$];
  sym_res_t          pending_symbols[$];
  logic [TIME_W-1:0] stamp_ms = '0;
  int                idle_pct = 35;
  int                n_samples = 0;
  int                n_writes = 0;
  int                n_overflow = 0;
  int                n_errors = 0;
  int                n_kind[4] = '{0, 0, 0, 0};

  function automatic logic [SYM_W-1:0] letter_of();
    if (ovf) return CH_UNKNOWN;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      if (SYM_ROM[i].len == elem_cnt && {2'b00, SYM_ROM[i].bits} == elem_bits)
        return SYM_ROM[i].ch;
    end
    return CH_UNKNOWN;
  endfunction

  task automatic decode_sample(input logic [SAMPLE_W-1:0] level,
                               input logic [TIME_W-1:0] stamp);
    logic              is_mark;
    logic              dash;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] dur;
    is_mark = level < thr_r;
    gap = stamp - last_done;
    step_res.delete();
    if ((elem_cnt != 0 || ovf) && gap > {16'd0, letter_gap_r}) begin
      if (ovf) n_overflow++;
      step_res.push_back('{letter_of(), KIND_LETTER, 1'b0});
      elem_bits = '0;
      elem_cnt = '0;
      ovf = 1'b0;
      if (gap > {16'd0, word_gap_r}) step_res.push_back('{CH_SPACE, KIND_SPACE, 1'b0});
    end
    case (ph)
      PH_MARK: begin
        if (!is_mark) begin
          mark_end = stamp;
          ph = PH_DEBOUNCE;
        end
      end
      PH_DEBOUNCE: begin
        held = stamp - mark_end;
        if (is_mark) begin
          ph = PH_MARK;
        end else if (held >= {16'd0, debounce_r}) begin
          dur = mark_end - mark_start;
          if (dur > {16'd0, min_mark_r}) begin
            dash = dur >= {16'd0, dash_min_r};
            step_res.push_back(dash ? sym_res_t'{CH_DASH, KIND_DASH, 1'b0}
                                    : sym_res_t'{CH_DOT, KIND_DOT, 1'b0});
            if (elem_cnt < 3'(CODE_MAX_DEF)) begin
              if (dash) elem_bits[elem_cnt] = 1'b1;
              elem_cnt++;
            end else begin
              ovf = 1'b1;
            end
          end
          last_done = stamp;
          ph = PH_IDLE;
        end
      end
      default: begin
        if (is_mark) begin
          mark_start = stamp;
          ph = PH_MARK;
        end
      end
    endcase
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] level, input logic [TIME_W-1:0] stamp,
                             input logic typed = 1'b0, input sym_res_t typed_res = '0);
    logic rdy;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, stamp, level};
    do begin
      @(negedge clk);
      rdy = (in_tready === 1'b1);
      @(posedge clk);
    end while (!rdy);
    decode_sample(level, stamp);
    if (typed) pending_symbols.push_back(typed_res);
    else foreach (step_res[i]) pending_symbols.push_back(step_res[i]);
    n_samples++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] val);
    logic rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      rdy = (cfg_ready === 1'b1);
      @(posedge clk);
    end while (!rdy);
    case (idx)
      CFG_THRESHOLD:  thr_r = val[SAMPLE_W-1:0];
      CFG_DEBOUNCE:   debounce_r = val;
      CFG_MIN_MARK:   min_mark_r = val;
      CFG_DASH_MIN:   dash_min_r = val;
      CFG_LETTER_GAP: letter_gap_r = val;
      CFG_WORD_GAP:   word_gap_r = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    n_writes++;
    @(posedge clk);
  endtask

  // wait for all results, then wait out samples that yield nothing
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_symbols.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_timings(input logic [MS_W-1:0] thr, input logic [MS_W-1:0] deb,
                             input logic [MS_W-1:0] mn, input logic [MS_W-1:0] dsh,
                             input logic [MS_W-1:0] lg, input logic [MS_W-1:0] wg);
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_MIN_MARK, mn);
    write_reg(CFG_DASH_MIN, dsh);
    write_reg(CFG_LETTER_GAP, lg);
    write_reg(CFG_WORD_GAP, wg);
  endtask

  function automatic logic [SAMPLE_W-1:0] mark_level();
    if (thr_r == 0) return '0;
    return SAMPLE_W'($urandom_range(0, thr_r - 1));
  endfunction

  function automatic logic [SAMPLE_W-1:0] space_level();
    return SAMPLE_W'($urandom_range(thr_r, 4095));
  endfunction

  function automatic logic [TIME_W-1:0] pick_duration();
    logic [TIME_W-1:0] lo;
    logic [TIME_W-1:0] hi;
    lo = min_mark_r + 1;
    hi = (dash_min_r > lo) ? dash_min_r - 1 : lo;
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, min_mark_r);
      1, 2: return $urandom_range(lo, hi);
      3: return dash_min_r + $urandom_range(0, 400);
      default: begin
        case ($urandom_range(0, 3))
          0: return TIME_W'(min_mark_r);
          1: return lo;
          2: return (dash_min_r == 0) ? 0 : dash_min_r - 1;
          default: return TIME_W'(dash_min_r);
        endcase
      end
    endcase
  endfunction

  // one letter of marks and rises, with dips, early rises and dropped confirms mixed in
  task automatic send_letter();
    int                n_el;
    logic [TIME_W-1:0] dur;
    n_el = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 5);
    for (int e = 0; e < n_el; e++) begin
      if (e > 0) stamp_ms += $urandom_range(0, letter_gap_r);
      dur = pick_duration();
      send_sample(mark_level(), stamp_ms);
      if ($urandom_range(0, 3) == 0) send_sample(mark_level(), stamp_ms + $urandom_range(0, dur));
      stamp_ms += dur;
      send_sample(space_level(), stamp_ms);
      if ($urandom_range(0, 5) == 0) begin
        stamp_ms += $urandom_range(0, debounce_r);
        send_sample(mark_level(), stamp_ms);
        stamp_ms += $urandom_range(0, 200);
        send_sample(space_level(), stamp_ms);
      end
      if (debounce_r != 0 && $urandom_range(0, 3) == 0)
        send_sample(space_level(), stamp_ms + $urandom_range(0, debounce_r - 1));
      if ($urandom_range(0, 19) != 0) begin
        stamp_ms += debounce_r + $urandom_range(0, 30);
        send_sample(space_level(), stamp_ms);
      end
    end
    case ($urandom_range(0, 3))
      0: stamp_ms += $urandom_range(0, letter_gap_r);
      1: stamp_ms += $urandom_range(letter_gap_r + 1,
                                    (word_gap_r > letter_gap_r) ? word_gap_r : letter_gap_r + 1);
      default: stamp_ms += word_gap_r + 1 + $urandom_range(0, 500);
    endcase
    if ($urandom_range(0, 1) == 0) send_sample(space_level(), stamp_ms);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) begin
      stamp_ms += ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2 * letter_gap_r + 100);
      send_sample(SAMPLE_W'($urandom_range(0, 4095)), stamp_ms);
    end
  endtask

  task automatic run_traffic(input int n_items);
    int stop_at;
    stop_at = n_samples + n_items;
    stamp_ms = $urandom;
    while (n_samples < stop_at) begin
      if ($urandom_range(0, 99) < 80) send_letter();
      else send_noise();
    end
  endtask

  always @(posedge clk) out_tready <= ($urandom_range(0, 99) >= idle_pct);

  always @(negedge clk) begin
    sym_res_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready) begin
      if (pending_symbols.size() == 0) begin
        $error("result with no request pending: symbol %h kind %0d", out_tdata[6:0], out_tuser);
        n_errors++;
      end else begin
        want = pending_symbols.pop_front();
        n_kind[want.kind]++;
        if (out_tdata[6:0] !== want.symbol) begin
          $error("symbol: expected %h, got %h", want.symbol, out_tdata[6:0]);
          n_errors++;
        end
        if (out_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_tuser);
          n_errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    sym_res_t fixed;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < 26; i++) begin
      fixed = '{DIR_ROWS[i].symbol, DIR_ROWS[i].kind, 1'b1};
      send_sample(DIR_ROWS[i].level, DIR_ROWS[i].stamp, DIR_ROWS[i].typed, fixed);
    end
    settle();

    set_timings(MS_W'($urandom_range(300, 3800)), MS_W'($urandom_range(0, 120)),
                MS_W'($urandom_range(0, 200)), min_mark_r, letter_gap_r, word_gap_r);
    write_reg(CFG_DASH_MIN, MS_W'(min_mark_r + $urandom_range(1, 500)));
    write_reg(CFG_LETTER_GAP, MS_W'(dash_min_r + $urandom_range(0, 1500)));
    write_reg(CFG_WORD_GAP, MS_W'(letter_gap_r + $urandom_range(0, 1500)));
    run_traffic(120);
    settle();

    // zero timings but dash 1, threshold written too wide, writes to unused indexes
    idle_pct = 0;
    set_timings(16'hFFFF, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0);
    write_reg(CFG_UNUSED_LO, MS_W'($urandom));
    write_reg(CFG_UNUSED_HI, MS_W'($urandom));
    run_traffic(100);
    settle();
    idle_pct = 35;

    set_timings(16'd2048, 16'hFFFF, 16'd1000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_traffic(80);
    settle();

    // nothing counts as a mark
    write_reg(CFG_THRESHOLD, 16'd0);
    send_noise();
    send_noise();
    settle();

    set_timings(MS_W'($urandom_range(200, 3900)), MS_W'($urandom_range(0, 100)),
                MS_W'($urandom_range(20, 150)), 16'd400, 16'd900, 16'd1600);
    run_traffic(160);
    settle();

    $display("%0d samples over %0d register writes: %0d dots, %0d dashes",
             n_samples, n_writes, n_kind[KIND_DOT], n_kind[KIND_DASH]);
    $display("%0d letters (%0d with a full store), %0d word spaces",
             n_kind[KIND_LETTER], n_overflow, n_kind[KIND_SPACE]);
    if (n_errors == 0 && pending_symbols.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
